>>> sv/vfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared types, codes and face tables of the voxel face-culling mesher.
// ----------------------------------------------------------------------------
package vfc_pkg;

    localparam int COORD_W     = 5;                 // voxel coordinate bits
    localparam int DIM_W       = 6;                 // grid size and half-unit bits
    localparam int ADDR_W      = 3 * COORD_W;       // occupancy store address
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int COORD_LIMIT = 1 << COORD_W;
    localparam int FACE_NUM    = 6;
    localparam int VTX_NUM     = 6;
    localparam int FACE_W      = 3;
    localparam int VTX_W       = 3;
    localparam int CODE_W      = 3;
    localparam int CFG_IDX_W   = 2;

    localparam logic [FACE_W-1:0] LAST_FACE = FACE_W'(FACE_NUM - 1);
    localparam logic [VTX_W-1:0]  LAST_VTX  = VTX_W'(VTX_NUM - 1);

    // transaction kinds on the input stream
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_MESH  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_DEPTH  = 2'd2;

    // face codes
    localparam logic [CODE_W-1:0] CODE_FRONT = 3'd0;
    localparam logic [CODE_W-1:0] CODE_RIGHT = 3'd1;
    localparam logic [CODE_W-1:0] CODE_DOWN  = 3'd2;
    localparam logic [CODE_W-1:0] CODE_BACK  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_LEFT  = 3'd4;
    localparam logic [CODE_W-1:0] CODE_UP    = 3'd5;

    localparam logic [DIM_W-1:0] OFS_ZERO = 6'd0;
    localparam logic [DIM_W-1:0] OFS_INC  = 6'd1;
    localparam logic [DIM_W-1:0] OFS_DEC  = 6'h3f;

    typedef struct packed {
        logic [DIM_W-1:0] dx;
        logic [DIM_W-1:0] dy;
        logic [DIM_W-1:0] dz;
    } vfc_offset_t;

    // neighbour probe result
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              inb;
    } vfc_probe_t;

    // one emitted vertex
    typedef struct packed {
        logic              tex_v;
        logic              tex_u;
        logic [CODE_W-1:0] face_code;
        logic [DIM_W-1:0]  vert_z;
        logic [DIM_W-1:0]  vert_y;
        logic [DIM_W-1:0]  vert_x;
    } vfc_vertex_t;

    // grid size clamped to 1 .. lim
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r,
                                                 input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] d;
        d = r;
        if (d == '0) begin
            d = DIM_W'(1);
        end
        if (d > lim) begin
            d = lim;
        end
        return d;
    endfunction

    // neighbour offset in emission order (mod 64, so x-1 at x=0 lands out of range)
    function automatic vfc_offset_t nbr_offset(input logic [FACE_W-1:0] f);
        vfc_offset_t o;
        case (f)
            3'd0:    o = '{dx: OFS_ZERO, dy: OFS_ZERO, dz: OFS_DEC};
            3'd1:    o = '{dx: OFS_ZERO, dy: OFS_DEC,  dz: OFS_ZERO};
            3'd2:    o = '{dx: OFS_DEC,  dy: OFS_ZERO, dz: OFS_ZERO};
            3'd3:    o = '{dx: OFS_ZERO, dy: OFS_ZERO, dz: OFS_INC};
            3'd4:    o = '{dx: OFS_ZERO, dy: OFS_INC,  dz: OFS_ZERO};
            3'd5:    o = '{dx: OFS_INC,  dy: OFS_ZERO, dz: OFS_ZERO};
            default: o = '{dx: OFS_ZERO, dy: OFS_ZERO, dz: OFS_ZERO};
        endcase
        return o;
    endfunction

    function automatic logic [CODE_W-1:0] face_code_of(input logic [FACE_W-1:0] f);
        logic [CODE_W-1:0] c;
        case (f)
            3'd0:    c = CODE_FRONT;
            3'd1:    c = CODE_DOWN;
            3'd2:    c = CODE_RIGHT;
            3'd3:    c = CODE_BACK;
            3'd4:    c = CODE_UP;
            3'd5:    c = CODE_LEFT;
            default: c = CODE_FRONT;
        endcase
        return c;
    endfunction

    // vertex corner bits: {v, u, dz, dy, dx}
    function automatic logic [4:0] vtx_bits(input logic [FACE_W-1:0] f,
                                            input logic [VTX_W-1:0] i);
        logic [4:0] t [VTX_NUM];
        logic [4:0] b;
        case (f)
            3'd0:    t = '{5'b00000, 5'b01001, 5'b11011, 5'b11011, 5'b10010, 5'b00000};
            3'd1:    t = '{5'b10101, 5'b11001, 5'b01000, 5'b01000, 5'b00100, 5'b10101};
            3'd2:    t = '{5'b10010, 5'b00000, 5'b01100, 5'b01100, 5'b11110, 5'b10010};
            3'd3:    t = '{5'b10111, 5'b00101, 5'b01100, 5'b01100, 5'b11110, 5'b10111};
            3'd4:    t = '{5'b11010, 5'b01011, 5'b00111, 5'b00111, 5'b10110, 5'b11010};
            3'd5:    t = '{5'b00101, 5'b01001, 5'b11011, 5'b11011, 5'b10111, 5'b00101};
            default: t = '{5'b00000, 5'b00000, 5'b00000, 5'b00000, 5'b00000, 5'b00000};
        endcase
        case (i)
            3'd0:    b = t[0];
            3'd1:    b = t[1];
            3'd2:    b = t[2];
            3'd3:    b = t[3];
            3'd4:    b = t[4];
            3'd5:    b = t[5];
            default: b = 5'b00000;
        endcase
        return b;
    endfunction

endpackage

>>> sv/vfc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module vfc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/vfc_nbr_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_nbr_unit
// Shared neighbour unit: offset add, grid bounds compare and store address.
// ----------------------------------------------------------------------------
module vfc_nbr_unit (
    input  logic [vfc_pkg::COORD_W-1:0] pos_x,
    input  logic [vfc_pkg::COORD_W-1:0] pos_y,
    input  logic [vfc_pkg::COORD_W-1:0] pos_z,
    input  logic [vfc_pkg::FACE_W-1:0]  face,
    input  logic [vfc_pkg::DIM_W-1:0]   dim_w,
    input  logic [vfc_pkg::DIM_W-1:0]   dim_h,
    input  logic [vfc_pkg::DIM_W-1:0]   dim_d,
    output vfc_pkg::vfc_probe_t         probe
);
    import vfc_pkg::*;

    vfc_offset_t      ofs;
    logic [DIM_W-1:0] ax;
    logic [DIM_W-1:0] ay;
    logic [DIM_W-1:0] az;

    always_comb begin
        ofs = nbr_offset(face);
        // wraps to 63 below zero, which is always outside the grid
        ax  = {1'b0, pos_x} + ofs.dx;
        ay  = {1'b0, pos_y} + ofs.dy;
        az  = {1'b0, pos_z} + ofs.dz;
        probe.inb  = (ax < dim_w) && (ay < dim_h) && (az < dim_d);
        probe.addr = {az[COORD_W-1:0], ay[COORD_W-1:0], ax[COORD_W-1:0]};
    end

endmodule

>>> sv/vfc_vertex_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_vertex_gen
// Builds one vertex from the voxel position, face and corner index.
// ----------------------------------------------------------------------------
module vfc_vertex_gen (
    input  logic [vfc_pkg::COORD_W-1:0] pos_x,
    input  logic [vfc_pkg::COORD_W-1:0] pos_y,
    input  logic [vfc_pkg::COORD_W-1:0] pos_z,
    input  logic [vfc_pkg::FACE_W-1:0]  face,
    input  logic [vfc_pkg::VTX_W-1:0]   vidx,
    output vfc_pkg::vfc_vertex_t        vtx
);
    import vfc_pkg::*;

    logic [4:0] bits;

    always_comb begin
        bits          = vtx_bits(face, vidx);
        // half units: 2*pos plus the corner offset
        vtx.vert_x    = {pos_x, bits[0]};
        vtx.vert_y    = {pos_y, bits[1]};
        vtx.vert_z    = {pos_z, bits[2]};
        vtx.tex_u     = bits[3];
        vtx.tex_v     = bits[4];
        vtx.face_code = face_code_of(face);
    end

endmodule

>>> sv/voxel_face_cull_mesher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_cull_mesher
// Face-culling mesher over a 32x32x32 one-bit voxel occupancy grid.
// ----------------------------------------------------------------------------
// A store transaction writes one occupancy bit. A mesh transaction reads
// the named voxel and then its six neighbours one per cycle through a
// single-port occupancy RAM and one shared neighbour address/bounds unit;
// after that each visible face sends six vertices at one per cycle while
// the output is not stalled, and each hidden face ahead of the last
// visible one is skipped. A mesh transaction on a voxel outside the grid
// finishes at once. The input is not ready while a mesh transaction is in
// work, but the next one is taken while the final vertex still waits in the
// output register. Occupancy entries must be written before they are meshed;
// there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module voxel_face_cull_mesher #(
    parameter int GRID_DIM_MAX = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pos_x[4:0], pos_y[9:5], pos_z[14:10], voxel_value[22:15]
    input  logic        s_tuser,   // operation
    // vertex stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // vert_x[5:0], vert_y[11:6], vert_z[17:12],
                                   // face_code[20:18], tex_u[21], tex_v[22]
    output logic        m_tlast    // last_vertex
);
    import vfc_pkg::*;

    localparam logic [DIM_W-1:0] DimLimit =
        DIM_W'((GRID_DIM_MAX < COORD_LIMIT) ? GRID_DIM_MAX : COORD_LIMIT);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SELF  = 4'b0010,
        ST_PROBE = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [DIM_W-1:0] grid_width_reg, grid_height_reg, grid_depth_reg;
    logic [DIM_W-1:0] dim_w, dim_h, dim_d;

    logic [COORD_W-1:0] in_x, in_y, in_z;
    logic [7:0]         in_value;
    logic               s_acc;
    logic               in_grid;

    logic [COORD_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;

    logic [FACE_W-1:0]   rd_face_reg, rd_face_next;
    logic                rd_inb_reg, rd_inb_next;
    logic [FACE_NUM-1:0] mask_reg, mask_next;
    logic [FACE_NUM-1:0] mask_hit;
    logic [FACE_W-1:0]   emit_face_reg, emit_face_next;
    logic [VTX_W-1:0]    vtx_reg, vtx_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic        m_tlast_reg, m_tlast_next;
    vfc_vertex_t out_vtx_reg;
    logic        out_load;

    logic [FACE_W-1:0] probe_face;
    vfc_probe_t        probe;
    vfc_vertex_t       vtx_gen;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic              ram_wdata;
    logic              ram_rdata;

    // input unpacking
    assign in_x     = s_tdata[4:0];
    assign in_y     = s_tdata[9:5];
    assign in_z     = s_tdata[14:10];
    assign in_value = s_tdata[22:15];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= DIM_W'(32);
            grid_height_reg <= DIM_W'(32);
            grid_depth_reg  <= DIM_W'(32);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                CFG_GRID_DEPTH:  grid_depth_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign dim_w = eff_dim(grid_width_reg, DimLimit);
    assign dim_h = eff_dim(grid_height_reg, DimLimit);
    assign dim_d = eff_dim(grid_depth_reg, DimLimit);

    assign in_grid = ({1'b0, in_x} < dim_w) && ({1'b0, in_y} < dim_h)
                  && ({1'b0, in_z} < dim_d);

    // shared neighbour unit: face 0 while the self read returns, then the next face
    assign probe_face = (state_reg == ST_SELF) ? '0 : rd_face_reg + FACE_W'(1);

    vfc_nbr_unit u_nbr (
        .pos_x (pos_x_reg),
        .pos_y (pos_y_reg),
        .pos_z (pos_z_reg),
        .face  (probe_face),
        .dim_w (dim_w),
        .dim_h (dim_h),
        .dim_d (dim_d),
        .probe (probe)
    );

    // occupancy store
    always_comb begin
        ram_we    = s_acc && (s_tuser == OP_STORE);
        ram_wdata = |in_value;
        ram_addr  = {in_z, in_y, in_x};
        if (state_reg == ST_SELF || state_reg == ST_PROBE) begin
            ram_addr = probe.addr;
        end
    end

    vfc_ram #(
        .WIDTH (1),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    vfc_vertex_gen u_vgen (
        .pos_x (pos_x_reg),
        .pos_y (pos_y_reg),
        .pos_z (pos_z_reg),
        .face  (emit_face_reg),
        .vidx  (vtx_reg),
        .vtx   (vtx_gen)
    );

    assign mask_hit = FACE_NUM'(rd_inb_reg && !ram_rdata) << rd_face_reg;

    // sequencer
    always_comb begin
        state_next     = state_reg;
        rd_face_next   = rd_face_reg;
        rd_inb_next    = rd_inb_reg;
        mask_next      = mask_reg;
        emit_face_next = emit_face_reg;
        vtx_next       = vtx_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tlast_next   = m_tlast_reg;
        out_load       = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_tuser == OP_MESH && in_grid) begin
                    state_next = ST_SELF;
                end
            end
            ST_SELF: begin
                if (!ram_rdata) begin
                    state_next = ST_IDLE;
                end else begin
                    rd_face_next = '0;
                    rd_inb_next  = probe.inb;
                    mask_next    = '0;
                    state_next   = ST_PROBE;
                end
            end
            ST_PROBE: begin
                mask_next = mask_reg | mask_hit;
                if (rd_face_reg == LAST_FACE) begin
                    emit_face_next = '0;
                    vtx_next       = '0;
                    state_next     = (mask_next != '0) ? ST_EMIT : ST_IDLE;
                end else begin
                    rd_face_next = rd_face_reg + FACE_W'(1);
                    rd_inb_next  = probe.inb;
                end
            end
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    if (mask_reg[emit_face_reg]) begin
                        out_load      = 1'b1;
                        m_tvalid_next = 1'b1;
                        if (vtx_reg == LAST_VTX) begin
                            vtx_next       = '0;
                            mask_next      = mask_reg & ~(FACE_NUM'(1) << emit_face_reg);
                            emit_face_next = emit_face_reg + FACE_W'(1);
                            m_tlast_next   = (mask_next == '0);
                            if (mask_next == '0) begin
                                state_next = ST_IDLE;
                            end
                        end else begin
                            vtx_next     = vtx_reg + VTX_W'(1);
                            m_tlast_next = 1'b0;
                        end
                    end else begin
                        // hidden face: skip it
                        emit_face_next = emit_face_reg + FACE_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            rd_face_reg   <= '0;
            rd_inb_reg    <= 1'b0;
            mask_reg      <= '0;
            emit_face_reg <= '0;
            vtx_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            m_tvalid_reg  <= m_tvalid_next;
            rd_face_reg   <= rd_face_next;
            rd_inb_reg    <= rd_inb_next;
            mask_reg      <= mask_next;
            emit_face_reg <= emit_face_next;
            vtx_reg       <= vtx_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            pos_x_reg <= in_x;
            pos_y_reg <= in_y;
            pos_z_reg <= in_z;
        end
        if (out_load) begin
            out_vtx_reg <= vtx_gen;
            m_tlast_reg <= m_tlast_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {1'b0, out_vtx_reg};

endmodule
